@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the transcoder RTL.
// Each macro expands to one labelled concurrent assertion clocked on the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by front, queue, back and top level.
`default_nettype none

package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [5:0]  LOW_SURR_HEAD = 6'b110111;
    localparam logic [20:0] PLANE_OFFSET  = 21'h10000;

    // Sequence lengths held in the decoder state.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // One job per input byte that gives units: a run of replacement units,
    // then up to two tail units.
    typedef struct packed {
        logic [2:0]  rep_count;
        logic [1:0]  tail_count;
        logic [15:0] tail0;
        logic [15:0] tail1;
        logic        eot;
    } t_job;

endpackage

`default_nettype wire

@@ hw/rtl/u8u16_front.sv @@
// Front end: classifies each UTF-8 byte, keeps the sequence state and builds a job.
// Depends on u8u16_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u8u16_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_eot,
    output u8u16_pkg::t_job        o_job,
    output logic                   o_push
);

    logic [2:0]  r_len;
    logic [1:0]  r_cont;
    logic [20:0] r_accum;
    logic [2:0]  n_len;
    logic [1:0]  n_cont;
    logic [20:0] n_accum;

    logic        fresh;
    logic [1:0]  cont_new;
    logic [20:0] acc_new;
    logic [20:0] plane_val;
    u8u16_pkg::t_job job;

    assign cont_new  = r_cont + 2'd1;
    assign acc_new   = {r_accum[14:0], i_byte[5:0]};
    assign plane_val = acc_new - u8u16_pkg::PLANE_OFFSET;

    always_comb begin
        n_len          = r_len;
        n_cont         = r_cont;
        n_accum        = r_accum;
        fresh          = 1'b1;
        job.rep_count  = 3'd0;
        job.tail_count = 2'd0;
        job.tail0      = 16'd0;
        job.tail1      = 16'd0;
        job.eot        = i_eot;

        if (r_len != u8u16_pkg::SEQ_NONE) begin
            if (i_byte[7:6] == 2'b10) begin
                fresh = 1'b0;
                if (({1'b0, cont_new} + 3'd1) >= r_len) begin
                    if (acc_new[20:16] == 5'd0) begin
                        job.tail_count = 2'd1;
                        job.tail0      = acc_new[15:0];
                    end else begin
                        job.tail_count = 2'd2;
                        job.tail0      = u8u16_pkg::HIGH_SURR + {5'd0, plane_val[20:10]};
                        job.tail1      = {u8u16_pkg::LOW_SURR_HEAD, plane_val[9:0]};
                    end
                    n_len   = u8u16_pkg::SEQ_NONE;
                    n_cont  = 2'd0;
                    n_accum = 21'd0;
                end else begin
                    n_cont  = cont_new;
                    n_accum = acc_new;
                end
            end else begin
                // drop the broken sequence: one unit for the lead, one per continuation
                job.rep_count = 3'd1 + {1'b0, r_cont};
                n_len   = u8u16_pkg::SEQ_NONE;
                n_cont  = 2'd0;
                n_accum = 21'd0;
            end
        end

        if (fresh) begin
            if (i_byte[7] == 1'b0) begin
                job.tail_count = 2'd1;
                job.tail0      = {8'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_len   = u8u16_pkg::SEQ_TWO;
                n_cont  = 2'd0;
                n_accum = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_len   = u8u16_pkg::SEQ_THREE;
                n_cont  = 2'd0;
                n_accum = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_len   = u8u16_pkg::SEQ_FOUR;
                n_cont  = 2'd0;
                n_accum = {18'd0, i_byte[2:0]};
            end else begin
                job.rep_count = job.rep_count + 3'd1;
            end
        end

        // unfinished sequence at end of text
        if (i_eot && (n_len != u8u16_pkg::SEQ_NONE)) begin
            job.rep_count = job.rep_count + 3'd1 + {1'b0, n_cont};
            n_len   = u8u16_pkg::SEQ_NONE;
            n_cont  = 2'd0;
            n_accum = 21'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= u8u16_pkg::SEQ_NONE;
            r_cont  <= 2'd0;
            r_accum <= 21'd0;
        end else if (i_accept) begin
            r_len   <= n_len;
            r_cont  <= n_cont;
            r_accum <= n_accum;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && ((job.rep_count != 3'd0) || (job.tail_count != 2'd0));

    `ASSERT_IMPL(a_cont_below_len, i_clk, i_rst_n, r_len != u8u16_pkg::SEQ_NONE,
        ({1'b0, r_cont} + 3'd1) < r_len, "continuation count reached sequence length")
    `ASSERT_IMPL(a_idle_no_cont, i_clk, i_rst_n, r_len == u8u16_pkg::SEQ_NONE,
        r_cont == 2'd0, "continuation count set with no sequence open")

endmodule

`default_nettype wire

@@ hw/rtl/u8u16_queue.sv @@
// Short job queue between the front end and the unit expander.
// Depends on u8u16_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u8u16_pkg::t_job   i_job,
    input  wire logic              i_pop,
    output u8u16_pkg::t_job        o_job,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8u16_pkg::t_job r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push, "push into full job queue")
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, o_empty, !i_pop, "pop from empty job queue")

endmodule

`default_nettype wire

@@ hw/rtl/u8u16_back.sv @@
// Back end: expands queued jobs into code units in an output register, one per cycle
// while the output is not stalled. Depends on u8u16_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u8u16_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire u8u16_pkg::t_job   i_job,
    input  wire logic              i_job_valid,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [15:0]            o_unit,
    output logic                   o_last,
    output logic                   o_done
);

    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_last;
    logic        r_done;
    logic [1:0]  r_idx;

    logic        load;
    logic        at_end;
    logic [2:0]  total;
    logic [15:0] unit;

    assign total  = i_job.rep_count + {1'b0, i_job.tail_count};
    assign at_end = ({1'b0, r_idx} + 3'd1) == total;
    assign load   = !r_valid || i_tready;
    assign o_pop  = load && i_job_valid && at_end;

    always_comb begin
        if ({1'b0, r_idx} < i_job.rep_count) begin
            unit = u8u16_pkg::REPLACEMENT;
        end else if ({1'b0, r_idx} == i_job.rep_count) begin
            unit = i_job.tail0;
        end else begin
            unit = i_job.tail1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_unit <= unit;
            r_last <= at_end;
            r_done <= at_end && i_job.eot;
        end
    end

    assign o_tvalid = r_valid;
    assign o_unit   = r_unit;
    assign o_last   = r_last;
    assign o_done   = r_done;

    `ASSERT_IMPL(a_idx_in_job, i_clk, i_rst_n, i_job_valid, {1'b0, r_idx} < total,
        "unit index beyond the current job")
    `ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, r_valid && r_done, r_last,
        "end of text flagged on a unit that does not close its byte")

endmodule

`default_nettype wire

@@ hw/rtl/utf8_to_utf16_transcoder_top.sv @@
// UTF-8 to UTF-16 transcoder, streaming byte in and 16-bit code unit out. The decoder
// handles each accepted byte combinationally, so a byte can enter on every clock edge;
// the expander that feeds the output register sends out the units of each byte one at
// a time, from 0 to 4 of them (surrogate pairs and replacement bursts). A job queue of
// QUEUE_DEPTH entries sits between the two, and the input ready drops only while that
// queue is full. Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
`default_nettype none

module utf8_to_utf16_transcoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // end_of_text
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] code_unit
    output logic             o_m_axis_tlast,   // run_last
    output logic             o_m_axis_tuser    // [0] text_done
);

    u8u16_pkg::t_job push_job;
    u8u16_pkg::t_job head_job;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    logic            accept;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eot    (i_s_axis_tlast),
        .o_job    (push_job),
        .o_push   (push)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (!q_empty),
        .o_pop       (pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_unit      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_done      (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
